// ===== src/laplacian_3x3_filter_macros.svh =====
// ----------------------------------------------------------------------------
// laplacian_3x3_filter_macros
// assertion macros shared by the checker of the laplacian filter
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_3X3_FILTER_MACROS_SVH
`define LAPLACIAN_3X3_FILTER_MACROS_SVH

// same-cycle implication, clocked on clk and disabled in reset
`define LAP3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("laplacian filter check failed");

// next-cycle implication, clocked on clk and disabled in reset
`define LAP3_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("laplacian filter check failed");

`endif

// ===== src/lap3_pkg.sv =====
// ----------------------------------------------------------------------------
// lap3_pkg
// types and constants of the 3x3 four-neighbour laplacian filter
// ----------------------------------------------------------------------------
package lap3_pkg;

    localparam int MAX_WIDTH = 512;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 10;
    localparam int HEIGHT_W  = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    localparam logic [WIDTH_W-1:0]  MIN_W   = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  LIMIT_W = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] MIN_H   = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] ROW_MAX = {HEIGHT_W{1'b1}};

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SHARPEN_MODE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              due;
        logic              border;
        logic              last;
        logic [ADDR_W-1:0] col;
        logic [PIX_W-1:0]  pix;
    } s1_info_t;

endpackage

// ===== src/lap3_pos_ctrl.sv =====
// ----------------------------------------------------------------------------
// lap3_pos_ctrl
// raster position counters, output position flags and the stage-one register
// ----------------------------------------------------------------------------
module lap3_pos_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          advance,
    input  logic                          kind,
    input  logic [lap3_pkg::PIX_W-1:0]    pixel_in,
    input  logic [lap3_pkg::WIDTH_W-1:0]  eff_w,
    input  logic [lap3_pkg::HEIGHT_W-1:0] eff_h,
    output logic                          take,
    output logic [lap3_pkg::ADDR_W-1:0]   col_addr,
    output logic [lap3_pkg::PIX_W-1:0]    pix,
    output logic                          s1_valid,
    output lap3_pkg::s1_info_t            s1_info
);
    import lap3_pkg::*;

    logic [ADDR_W-1:0]   col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic                s1_valid_reg, s1_valid_next;
    s1_info_t            s1_info_reg;

    logic                due, drain, col_zero, border, last, wrap;
    logic [HEIGHT_W-1:0] orow, h_m1;
    logic [WIDTH_W-1:0]  ocol, w_m1, col_inc;

    always_comb
    begin
        drain    = (kind == KIND_DRAIN);
        col_zero = (col_reg == '0);
        due      = (row_reg >= HEIGHT_W'(2)) || ((row_reg == HEIGHT_W'(1)) && !col_zero);
        take     = accept && !(drain && !due);
        pix      = drain ? '0 : pixel_in;
        w_m1     = eff_w - WIDTH_W'(1);
        h_m1     = eff_h - HEIGHT_W'(1);
        orow     = col_zero ? (row_reg - HEIGHT_W'(2)) : (row_reg - HEIGHT_W'(1));
        ocol     = col_zero ? w_m1 : ({1'b0, col_reg} - WIDTH_W'(1));
        border   = col_zero || (orow == '0) || (orow >= h_m1) || (ocol == '0) || (ocol >= w_m1);
        last     = due && (orow >= h_m1) && (ocol >= w_m1);
        col_inc  = {1'b0, col_reg} + WIDTH_W'(1);
        wrap     = (col_inc >= eff_w);

        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (wrap)
            begin
                col_next = '0;
                if (row_reg != ROW_MAX)
                begin
                    row_next = row_reg + HEIGHT_W'(1);
                end
            end
            else
            begin
                col_next = col_inc[ADDR_W-1:0];
            end
        end

        s1_valid_next = advance ? take : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_info_reg.due    <= due;
            s1_info_reg.border <= border;
            s1_info_reg.last   <= last;
            s1_info_reg.col    <= col_reg;
            s1_info_reg.pix    <= pix;
        end
    end

    assign col_addr = col_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_info  = s1_info_reg;

endmodule

// ===== src/lap3_line_store.sv =====
// ----------------------------------------------------------------------------
// lap3_line_store
// upper and middle line memories with registered read data
// ----------------------------------------------------------------------------
module lap3_line_store (
    input  logic                        clk,
    input  logic                        take,
    input  logic [lap3_pkg::ADDR_W-1:0] addr,
    input  logic [lap3_pkg::PIX_W-1:0]  pix,
    input  logic                        wb_en,
    input  logic [lap3_pkg::ADDR_W-1:0] wb_addr,
    output logic [lap3_pkg::PIX_W-1:0]  top_rd,
    output logic [lap3_pkg::PIX_W-1:0]  mid_rd
);
    import lap3_pkg::*;

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mid_rd_reg       <= middle_mem[addr];
            middle_mem[addr] <= pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            top_rd_reg <= upper_mem[addr];
        end
        if (wb_en)
        begin
            upper_mem[wb_addr] <= mid_rd_reg;
        end
    end

    assign top_rd = top_rd_reg;
    assign mid_rd = mid_rd_reg;

endmodule

// ===== src/lap3_window_calc.sv =====
// ----------------------------------------------------------------------------
// lap3_window_calc
// window registers, laplacian response, sharpen option and saturation
// ----------------------------------------------------------------------------
module lap3_window_calc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       consume,
    input  logic                       sharpen,
    input  logic [lap3_pkg::PIX_W-1:0] top_rd,
    input  logic [lap3_pkg::PIX_W-1:0] mid_rd,
    input  lap3_pkg::s1_info_t         s1_info,
    output logic [lap3_pkg::PIX_W-1:0] result
);
    import lap3_pkg::*;

    localparam int SUM_W = PIX_W + 2;
    localparam int RES_W = PIX_W + 5;

    logic [PIX_W-1:0] top2_reg, mid1_reg, mid2_reg, bot2_reg;

    logic [SUM_W-1:0]        nsum;
    logic signed [RES_W-1:0] lap, sharp, val;
    logic [PIX_W-1:0]        clamped;

    always_comb
    begin
        nsum  = SUM_W'(top2_reg) + SUM_W'(bot2_reg) + SUM_W'(mid1_reg) + SUM_W'(mid_rd);
        lap   = $signed(RES_W'(nsum)) - $signed(RES_W'({mid2_reg, 2'b00}));
        sharp = $signed(RES_W'(mid2_reg)) - lap;
        val   = sharpen ? sharp : lap;
        if (val < 0)
        begin
            clamped = '0;
        end
        else if (val > $signed(RES_W'({PIX_W{1'b1}})))
        begin
            clamped = '1;
        end
        else
        begin
            clamped = val[PIX_W-1:0];
        end
        result = s1_info.border ? mid2_reg : clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top2_reg <= '0;
            mid1_reg <= '0;
            mid2_reg <= '0;
            bot2_reg <= '0;
        end
        else if (consume)
        begin
            top2_reg <= top_rd;
            mid1_reg <= mid2_reg;
            mid2_reg <= mid_rd;
            bot2_reg <= s1_info.pix;
        end
    end

endmodule

// ===== src/laplacian_3x3_filter.sv =====
// ----------------------------------------------------------------------------
// laplacian_3x3_filter
// 3x3 four-neighbour laplacian / sharpen filter on a raster luma stream
// an accepted item passes the stage-one register and then the output register
// throughput: one item per cycle while the output is not stalled, set by the single-port line store read per item
// in stream terms a result lags its input by one line plus one pixel
// reset: async active low, clears position, window and output valid, loads
// default registers; line stores are not cleared
// ----------------------------------------------------------------------------
module laplacian_3x3_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [lap3_pkg::PIX_W-1:0]     pixel_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lap3_pkg::PIX_W-1:0]     pixel_out,
    output logic                           frame_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lap3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lap3_pkg::CFG_DAT_W-1:0] cfg_data
);
    import lap3_pkg::*;

    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic                sharpen_mode_reg;
    logic                out_valid_reg;
    logic [PIX_W-1:0]    pixel_out_reg;
    logic                frame_last_reg;

    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                advance, accept, take, consume, s1_valid;
    logic [ADDR_W-1:0]   col_addr;
    logic [PIX_W-1:0]    pix, top_rd, mid_rd, result;
    s1_info_t            s1_info;

    always_comb
    begin
        if (frame_width_reg < MIN_W)
        begin
            eff_w = MIN_W;
        end
        else if (frame_width_reg > LIMIT_W)
        begin
            eff_w = LIMIT_W;
        end
        else
        begin
            eff_w = frame_width_reg;
        end
        eff_h   = (frame_height_reg < MIN_H) ? MIN_H : frame_height_reg;
        advance = !out_valid_reg || out_ready;
        accept  = in_valid && advance;
        consume = s1_valid && advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_W'(416);
            frame_height_reg <= HEIGHT_W'(240);
            sharpen_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_SHARPEN_MODE: sharpen_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid && s1_info.due;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            pixel_out_reg  <= result;
            frame_last_reg <= s1_info.last;
        end
    end

    lap3_pos_ctrl u_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .advance  (advance),
        .kind     (kind),
        .pixel_in (pixel_in),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .take     (take),
        .col_addr (col_addr),
        .pix      (pix),
        .s1_valid (s1_valid),
        .s1_info  (s1_info)
    );

    lap3_line_store u_lines (
        .clk     (clk),
        .take    (take),
        .addr    (col_addr),
        .pix     (pix),
        .wb_en   (consume),
        .wb_addr (s1_info.col),
        .top_rd  (top_rd),
        .mid_rd  (mid_rd)
    );

    lap3_window_calc u_calc (
        .clk     (clk),
        .rst_n   (rst_n),
        .consume (consume),
        .sharpen (sharpen_mode_reg),
        .top_rd  (top_rd),
        .mid_rd  (mid_rd),
        .s1_info (s1_info),
        .result  (result)
    );

    assign in_ready   = advance;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

endmodule

// ===== src/lap3_checker.sv =====
// ----------------------------------------------------------------------------
// lap3_checker
// port-level checks of the laplacian filter, bound to the top level
// ----------------------------------------------------------------------------
`include "laplacian_3x3_filter_macros.svh"

module lap3_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] pixel_out,
    input logic       frame_last,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // stalled result holds
    `LAP3_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(frame_last))

    // empty output register never blocks the input
    `LAP3_ASSERT_IMP(a_in_free, !out_valid, in_ready)

    // a fresh result follows an earlier accepted item
    `LAP3_ASSERT_IMP(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2))

    // configuration writes are never refused
    `LAP3_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind laplacian_3x3_filter lap3_checker u_lap3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);
